@@ design/capsule_tlv_deframer_unit_assert.svh @@
// Assertion macros for the capsule deframer checker.
// Needs nothing else; include it by its bare file name.
`ifndef CAPSULE_TLV_DEFRAMER_UNIT_ASSERT_SVH
`define CAPSULE_TLV_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CTD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("capsule deframer check failed");

// Next-cycle implication, disabled while reset is high.
`define CTD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("capsule deframer check failed");

`endif

@@ design/ctd_pkg.sv @@
// Shared types and constants for the capsule TLV deframer.
// No dependencies; imported by the deframer, its varint unit and its checker.
`timescale 1ns / 1ps

package ctd_pkg;

   // Largest buffer size; remaining counts are clamped to one less than it.
   localparam longint CTD_MAX_BUFFER_BYTES = 65536;

   localparam int CTD_VARINT_W = 62;

   // Result kinds, carried on tuser.
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_VALUE  = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // Error codes.
   localparam logic ERR_TRUNCATED = 1'b0;
   localparam logic ERR_OVERRUN   = 1'b1;

   // Outcome of adding one byte to a varint.
   typedef struct packed {
      logic [CTD_VARINT_W-1:0] acc;
      logic [2:0]              left;
      logic                    done;
   } varint_result_type;

endpackage

@@ design/ctd_varint.sv @@
// Byte step of a QUIC variable-length integer decoder.
// Depends on ctd_pkg for the result struct.
`timescale 1ns / 1ps

module ctd_varint (
   input  logic                            first,
   input  logic [7:0]                      data_byte,
   input  logic [ctd_pkg::CTD_VARINT_W-1:0] acc,
   input  logic [2:0]                      left,
   output ctd_pkg::varint_result_type      result
);
   import ctd_pkg::*;

   logic [2:0] left_dec;
   logic [3:0] total;

   // A first byte sets the length from its prefix; later bytes shift in.
   always_comb begin
      total    = 4'd1 << data_byte[7:6];
      left_dec = (left != 3'd0) ? left - 3'd1 : 3'd0;
      if (first) begin
         result.acc  = {{(CTD_VARINT_W-6){1'b0}}, data_byte[5:0]};
         result.left = 3'(total - 4'd1);
      end else begin
         result.acc  = {acc[CTD_VARINT_W-9:0], data_byte};
         result.left = left_dec;
      end
      result.done = (result.left == 3'd0);
   end

endmodule

@@ design/capsule_tlv_deframer_unit.sv @@
// Top level of the capsule TLV deframer: parse state machine and result register.
// Depends on ctd_pkg and instantiates ctd_varint.
`timescale 1ns / 1ps

// Usage:
// The req channel carries one buffer byte per transfer: req_tdata holds the
// byte and the count of buffer bytes that follow it (0 marks the buffer end).
// The rsp channel carries at most one result per input byte: a decoded header,
// a passed-through value byte or an error. tuser gives the result kind and
// tlast marks the last value byte or the header of a zero-length capsule.
// Header bytes other than the last length byte, and bytes dropped after a
// length overrun, produce no result; a buffer end inside a header is an error.
// A result appears on rsp the cycle after its byte is transferred. Throughput is
// one byte per cycle while rsp is not stalled, set by the single result
// register, which is refilled in the same cycle it is drained.
// When the receiver stalls with a result pending, req_tready falls and the
// held result stays stable until it is transferred.
// Reset is synchronous: it returns the parser to waiting for a capsule type,
// clears the pending result and holds req_tready low while asserted.

module capsule_tlv_deframer_unit (
   input  logic         clock,
   input  logic         reset,
   // req_tdata: data_byte [7:0], bytes_remaining [23:8]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,
   // rsp_tdata: capsule_type [61:0], value_length [123:62], value_byte [131:124],
   //            error_code [132], zero fill [135:133]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,
   // rsp_tuser: result_kind [1:0]
   output logic [1:0]   rsp_tuser,
   // rsp_tlast: capsule_end
   output logic         rsp_tlast
);
   import ctd_pkg::*;

   typedef enum logic [2:0] {
      PH_TYPE_FIRST = 3'd0,
      PH_TYPE_REST  = 3'd1,
      PH_LEN_FIRST  = 3'd2,
      PH_LEN_REST   = 3'd3,
      PH_VALUE      = 3'd4,
      PH_DROP       = 3'd5
   } phase_type;

   localparam logic [32:0] REM_CAP = 33'(CTD_MAX_BUFFER_BYTES - 1);

   // Parser state.
   phase_type               phase_ff, phase_in;
   logic [2:0]              vleft_ff, vleft_in;
   logic [CTD_VARINT_W-1:0] acc_ff, acc_in;
   logic [CTD_VARINT_W-1:0] held_type_ff, held_type_in;
   logic [CTD_VARINT_W-1:0] held_length_ff, held_length_in;
   logic [15:0]             value_left_ff, value_left_in;

   // Result register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rsp_kind_ff, rsp_kind_in;
   logic [CTD_VARINT_W-1:0] rsp_type_ff, rsp_type_in;
   logic [CTD_VARINT_W-1:0] rsp_len_ff, rsp_len_in;
   logic [7:0]              rsp_byte_ff, rsp_byte_in;
   logic                    rsp_end_ff, rsp_end_in;
   logic                    rsp_err_ff, rsp_err_in;

   logic              accept;
   logic              emit;
   logic              header_open;
   logic              value_last;
   logic              varint_first;
   logic [7:0]        in_byte;
   logic [15:0]       in_rem;
   logic [15:0]       rem_eff;
   varint_result_type vres;

   assign in_byte = req_tdata[7:0];
   assign in_rem  = req_tdata[23:8];

   // Counts above one less than the largest buffer are clamped to that value.
   assign rem_eff = ({17'b0, in_rem} > REM_CAP) ? REM_CAP[15:0] : in_rem;

   // A new byte may enter whenever the result register is free or draining.
   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   // Only the continuation phases add to a varint already in progress.
   assign varint_first = !(phase_ff inside {PH_TYPE_REST, PH_LEN_REST});

   ctd_varint u_varint (
      .first     (varint_first),
      .data_byte (in_byte),
      .acc       (acc_ff),
      .left      (vleft_ff),
      .result    (vres)
   );

   // Next state and result for the byte on the input.
   always_comb begin
      phase_in       = phase_ff;
      vleft_in       = vleft_ff;
      acc_in         = acc_ff;
      held_type_in   = held_type_ff;
      held_length_in = held_length_ff;
      value_left_in  = value_left_ff;
      emit           = 1'b0;
      header_open    = 1'b0;
      value_last     = (value_left_ff <= 16'd1);
      rsp_kind_in    = KIND_HEADER;
      rsp_type_in    = '0;
      rsp_len_in     = '0;
      rsp_byte_in    = '0;
      rsp_end_in     = 1'b0;
      rsp_err_in     = ERR_TRUNCATED;

      case (phase_ff)
         PH_TYPE_REST: begin
            acc_in      = vres.acc;
            vleft_in    = vres.left;
            header_open = 1'b1;
            if (vres.done) begin
               held_type_in = vres.acc;
               phase_in     = PH_LEN_FIRST;
            end
         end
         PH_LEN_FIRST, PH_LEN_REST: begin
            acc_in   = vres.acc;
            vleft_in = vres.left;
            if (!vres.done) begin
               phase_in    = PH_LEN_REST;
               header_open = 1'b1;
            end else begin
               held_length_in = vres.acc;
               emit           = 1'b1;
               rsp_type_in    = held_type_ff;
               rsp_len_in     = vres.acc;
               if (vres.acc > {{(CTD_VARINT_W-16){1'b0}}, rem_eff}) begin
                  // Length overruns the buffer: drop the rest of it.
                  phase_in    = (rem_eff == 16'd0) ? PH_TYPE_FIRST : PH_DROP;
                  rsp_kind_in = KIND_ERROR;
                  rsp_err_in  = ERR_OVERRUN;
               end else if (vres.acc == '0) begin
                  phase_in   = PH_TYPE_FIRST;
                  rsp_end_in = 1'b1;
               end else begin
                  value_left_in = vres.acc[15:0];
                  phase_in      = PH_VALUE;
               end
            end
         end
         PH_VALUE: begin
            emit        = 1'b1;
            rsp_kind_in = KIND_VALUE;
            rsp_type_in = held_type_ff;
            rsp_len_in  = held_length_ff;
            rsp_byte_in = in_byte;
            rsp_end_in  = value_last;
            if (value_last) begin
               value_left_in = 16'd0;
               phase_in      = PH_TYPE_FIRST;
            end else begin
               value_left_in = value_left_ff - 16'd1;
            end
         end
         PH_DROP: begin
            if (rem_eff == 16'd0) begin
               phase_in = PH_TYPE_FIRST;
            end
         end
         default: begin
            // Waiting for a type's first byte; unused codes behave the same.
            acc_in      = vres.acc;
            vleft_in    = vres.left;
            header_open = 1'b1;
            if (vres.done) begin
               held_type_in = vres.acc;
               phase_in     = PH_LEN_FIRST;
            end else begin
               phase_in = PH_TYPE_REST;
            end
         end
      endcase

      // The buffer ended inside a header.
      if (header_open && (rem_eff == 16'd0)) begin
         phase_in    = PH_TYPE_FIRST;
         vleft_in    = 3'd0;
         acc_in      = '0;
         emit        = 1'b1;
         rsp_kind_in = KIND_ERROR;
         rsp_err_in  = ERR_TRUNCATED;
      end

      rsp_valid_in = accept ? emit : (rsp_valid_ff && !rsp_tready);
   end

   // State and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_TYPE_FIRST;
         vleft_ff       <= 3'd0;
         acc_ff         <= '0;
         held_type_ff   <= '0;
         held_length_ff <= '0;
         value_left_ff  <= 16'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff       <= phase_in;
            vleft_ff       <= vleft_in;
            acc_ff         <= acc_in;
            held_type_ff   <= held_type_in;
            held_length_ff <= held_length_in;
            value_left_ff  <= value_left_in;
         end
         if (accept && emit) begin
            rsp_kind_ff <= rsp_kind_in;
            rsp_type_ff <= rsp_type_in;
            rsp_len_ff  <= rsp_len_in;
            rsp_byte_ff <= rsp_byte_in;
            rsp_end_ff  <= rsp_end_in;
            rsp_err_ff  <= rsp_err_in;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_err_ff, rsp_byte_ff, rsp_len_ff, rsp_type_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_end_ff;

endmodule

@@ design/ctd_checker.sv @@
// Port-level checks for the capsule TLV deframer, bound to its top level.
// Depends on ctd_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "capsule_tlv_deframer_unit_assert.svh"

module ctd_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [135:0] rsp_tdata,
   input logic [1:0]   rsp_tuser,
   input logic         rsp_tlast
);
   import ctd_pkg::*;

   logic         rsp_stall;
   logic         is_error;
   logic         is_trunc;
   logic         err_code;
   logic [138:0] rsp_bundle;

   // Shorthands for the result channel.
   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign is_error   = rsp_tvalid && (rsp_tuser == KIND_ERROR);
   assign err_code   = rsp_tdata[132];
   assign is_trunc   = is_error && (err_code == ERR_TRUNCATED);
   assign rsp_bundle = {rsp_tlast, rsp_tuser, rsp_tdata};

   // A stalled result holds until its transfer.
   `CTD_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_bundle))

   // No byte enters while a stalled result would be overwritten.
   `CTD_ASSERT_IMP(a_no_overwrite, clock, reset, rsp_stall, !req_tready)

   // Errors never mark a capsule end.
   `CTD_ASSERT_IMP(a_err_no_end, clock, reset, is_error, !rsp_tlast)

   // The error code is clear on headers and value bytes.
   `CTD_ASSERT_IMP(a_code_clear, clock, reset, rsp_tvalid && !is_error, err_code == 1'b0)

   // A truncated header reports no type, length or byte.
   `CTD_ASSERT_IMP(a_trunc_zero, clock, reset, is_trunc, rsp_tdata[131:0] == '0)

endmodule

bind capsule_tlv_deframer_unit ctd_checker u_ctd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
